FILE: rtl/fajsj_pkg.sv
package fajsj_pkg;

    localparam int STEP_DIVISOR_DEF = 50;

    localparam logic signed [8:0] POS_MIN    = -9'sd2;
    localparam logic signed [8:0] POS_MAX    = 9'sd182;
    localparam logic signed [8:0] RESET_HOME = 9'sd90;

    localparam logic [6:0] DEAD_ZONE_RST  = 7'd2;
    localparam logic [7:0] HOME_ANGLE_RST = 8'd90;
    localparam logic [7:0] MAX_ANGLE_RST  = 8'd180;

    typedef logic signed [8:0]  t_pos;
    typedef logic signed [10:0] t_wide;

    typedef enum logic [1:0] {
        REG_DEAD_ZONE  = 2'd0,
        REG_HOME_ANGLE = 2'd1,
        REG_MAX_ANGLE  = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [6:0] dead_zone;
        logic [7:0] home_angle;
        logic [7:0] max_angle;
    } t_cfg;

    function automatic t_pos sat_pos(input t_wide v);
        t_pos r;
        if (v < t_wide'(POS_MIN)) begin
            r = POS_MIN;
        end else if (v > t_wide'(POS_MAX)) begin
            r = POS_MAX;
        end else begin
            r = $signed(v[8:0]);
        end
        return r;
    endfunction

endpackage

FILE: rtl/four_axis_joystick_servo_jog_top.sv
// Four-axis servo jog controller driven by joystick events.
// Input channel (i_valid/o_ready): one beat is one controller event with four
// signed stick values, their moved marks and four button presses.
// Output channel (o_valid/i_ready): one beat per event with the four joint
// angles clamped to 0..max_angle and the freeze and elbow-lock flags.
// The APB port writes dead_zone at 0x0, home_angle at 0x4 and max_angle at
// 0x8; pready is always high and reads return the register value.
// An accepted event waits in the input register; the state update and the output
// clamps are combinational and are registered into the result register.
// o_valid rises when the event moves from the input register into the result
// register; one event is accepted in every cycle while the receiver keeps
// i_ready high.
// When the receiver stalls, the result register holds its beat and the input
// register takes one more event, after which o_ready drops.
// Reset puts all four joints at 90, clears both flags, loads the register
// defaults and empties both stages.
module four_axis_joystick_servo_jog_top #(
    parameter int STEP_DIVISOR = fajsj_pkg::STEP_DIVISOR_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic signed [7:0] i_left_x,
    input  logic signed [7:0] i_left_y,
    input  logic signed [7:0] i_right_x,
    input  logic signed [7:0] i_right_y,
    input  logic              i_moved_left_x,
    input  logic              i_moved_left_y,
    input  logic              i_moved_right_x,
    input  logic              i_moved_right_y,
    input  logic              i_press_freeze,
    input  logic              i_press_lock,
    input  logic              i_press_home_left,
    input  logic              i_press_home_right,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_base_angle,
    output logic [7:0]        o_shoulder_angle,
    output logic [7:0]        o_elbow_angle,
    output logic [7:0]        o_wrist_angle,
    output logic              o_frozen,
    output logic              o_elbow_coupled
);

    typedef struct packed {
        logic signed [7:0] left_x;
        logic signed [7:0] left_y;
        logic signed [7:0] right_x;
        logic signed [7:0] right_y;
        logic              moved_left_x;
        logic              moved_left_y;
        logic              moved_right_x;
        logic              moved_right_y;
        logic              press_freeze;
        logic              press_lock;
        logic              press_home_left;
        logic              press_home_right;
    } t_event;

    fajsj_pkg::t_cfg  w_cfg;
    t_event           r_in;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             w_take;
    logic             w_fire;
    logic             w_active;

    fajsj_pkg::t_pos  r_base_pos, r_shoulder_pos, r_elbow_pos, r_wrist_pos;
    logic             r_freeze, r_lock;
    fajsj_pkg::t_pos  n_base_pos, n_shoulder_pos, n_elbow_pos, n_wrist_pos;
    logic             n_freeze, n_lock;

    fajsj_pkg::t_pos  w_home;
    fajsj_pkg::t_pos  w_base0, w_shoulder0, w_elbow_c, w_elbow0, w_wrist0;
    logic signed [7:0] w_base_step, w_shoulder_step, w_elbow_step, w_wrist_step;

    logic [7:0]       r_base_angle, r_shoulder_angle, r_elbow_angle, r_wrist_angle;

    function automatic logic [7:0] clamp_out(input fajsj_pkg::t_pos v,
                                             input logic [7:0] hi);
        logic [7:0] r;
        if (v < 9'sd0) begin
            r = 8'd0;
        end else if ($signed({1'b0, v}) > $signed({2'b00, hi})) begin
            r = hi;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

    fajsj_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_fire  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_fire;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_out_valid;

    assign w_home = (w_cfg.home_angle > 8'd182) ? fajsj_pkg::POS_MAX
                                                 : $signed({1'b0, w_cfg.home_angle});

    assign n_freeze = r_freeze ^ r_in.press_freeze;
    assign w_active = !n_freeze;
    assign n_lock   = r_lock ^ (w_active && r_in.press_lock);

    assign w_base0     = (w_active && r_in.press_home_left) ? w_home : r_base_pos;
    assign w_shoulder0 = (w_active && r_in.press_home_left) ? w_home : r_shoulder_pos;

    fajsj_joint #(.STEP_DIVISOR(STEP_DIVISOR)) u_base (
        .i_stick     (r_in.left_x),
        .i_move      (w_active && r_in.moved_left_x),
        .i_pos       (w_base0),
        .i_dead_zone (w_cfg.dead_zone),
        .i_max_angle (w_cfg.max_angle),
        .o_step      (w_base_step),
        .o_pos       (n_base_pos)
    );

    fajsj_joint #(.STEP_DIVISOR(STEP_DIVISOR)) u_shoulder (
        .i_stick     (r_in.left_y),
        .i_move      (w_active && r_in.moved_left_y),
        .i_pos       (w_shoulder0),
        .i_dead_zone (w_cfg.dead_zone),
        .i_max_angle (w_cfg.max_angle),
        .o_step      (w_shoulder_step),
        .o_pos       (n_shoulder_pos)
    );

    // With the lock set, the shoulder step carries into the elbow, saturated to POS_MIN..POS_MAX.
    assign w_elbow_c = n_lock
        ? fajsj_pkg::sat_pos(fajsj_pkg::t_wide'(r_elbow_pos)
                             + fajsj_pkg::t_wide'(w_shoulder_step))
        : r_elbow_pos;
    assign w_elbow0 = (w_active && r_in.press_home_right) ? w_home : w_elbow_c;
    assign w_wrist0 = (w_active && r_in.press_home_right) ? w_home : r_wrist_pos;

    fajsj_joint #(.STEP_DIVISOR(STEP_DIVISOR)) u_wrist (
        .i_stick     (r_in.right_x),
        .i_move      (w_active && r_in.moved_right_x),
        .i_pos       (w_wrist0),
        .i_dead_zone (w_cfg.dead_zone),
        .i_max_angle (w_cfg.max_angle),
        .o_step      (w_wrist_step),
        .o_pos       (n_wrist_pos)
    );

    fajsj_joint #(.STEP_DIVISOR(STEP_DIVISOR)) u_elbow (
        .i_stick     (r_in.right_y),
        .i_move      (w_active && r_in.moved_right_y),
        .i_pos       (w_elbow0),
        .i_dead_zone (w_cfg.dead_zone),
        .i_max_angle (w_cfg.max_angle),
        .o_step      (w_elbow_step),
        .o_pos       (n_elbow_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_base_pos     <= fajsj_pkg::RESET_HOME;
            r_shoulder_pos <= fajsj_pkg::RESET_HOME;
            r_elbow_pos    <= fajsj_pkg::RESET_HOME;
            r_wrist_pos    <= fajsj_pkg::RESET_HOME;
            r_freeze       <= 1'b0;
            r_lock         <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid    <= 1'b1;
                r_base_pos     <= n_base_pos;
                r_shoulder_pos <= n_shoulder_pos;
                r_elbow_pos    <= n_elbow_pos;
                r_wrist_pos    <= n_wrist_pos;
                r_freeze       <= n_freeze;
                r_lock         <= n_lock;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.left_x           <= i_left_x;
            r_in.left_y           <= i_left_y;
            r_in.right_x          <= i_right_x;
            r_in.right_y          <= i_right_y;
            r_in.moved_left_x     <= i_moved_left_x;
            r_in.moved_left_y     <= i_moved_left_y;
            r_in.moved_right_x    <= i_moved_right_x;
            r_in.moved_right_y    <= i_moved_right_y;
            r_in.press_freeze     <= i_press_freeze;
            r_in.press_lock       <= i_press_lock;
            r_in.press_home_left  <= i_press_home_left;
            r_in.press_home_right <= i_press_home_right;
        end
        if (w_fire) begin
            r_base_angle     <= clamp_out(n_base_pos, w_cfg.max_angle);
            r_shoulder_angle <= clamp_out(n_shoulder_pos, w_cfg.max_angle);
            r_elbow_angle    <= clamp_out(n_elbow_pos, w_cfg.max_angle);
            r_wrist_angle    <= clamp_out(n_wrist_pos, w_cfg.max_angle);
        end
    end

    assign o_base_angle     = r_base_angle;
    assign o_shoulder_angle = r_shoulder_angle;
    assign o_elbow_angle    = r_elbow_angle;
    assign o_wrist_angle    = r_wrist_angle;
    assign o_frozen         = r_freeze;
    assign o_elbow_coupled  = r_lock;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base_pos >= fajsj_pkg::POS_MIN && r_base_pos <= fajsj_pkg::POS_MAX
        && r_shoulder_pos >= fajsj_pkg::POS_MIN && r_shoulder_pos <= fajsj_pkg::POS_MAX
        && r_elbow_pos >= fajsj_pkg::POS_MIN && r_elbow_pos <= fajsj_pkg::POS_MAX
        && r_wrist_pos >= fajsj_pkg::POS_MIN && r_wrist_pos <= fajsj_pkg::POS_MAX)
        else $error("joint position outside the saturation range");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_base_pos) && $stable(r_shoulder_pos)
                    && $stable(r_elbow_pos) && $stable(r_wrist_pos)
                    && $stable(r_freeze) && $stable(r_lock))
        else $error("state changed without an event being processed");

    a_frozen_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_freeze && !r_in.press_freeze
        |=> $stable(r_base_pos) && $stable(r_shoulder_pos)
            && $stable(r_elbow_pos) && $stable(r_wrist_pos) && $stable(r_lock))
        else $error("joints moved while frozen");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid && r_in_valid == $past(w_take))
        else $error("processed event did not reach the result register");

endmodule

FILE: rtl/fajsj_cfg.sv
module fajsj_cfg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output fajsj_pkg::t_cfg     o_cfg
);

    fajsj_pkg::t_cfg     r_cfg;
    fajsj_pkg::t_reg_idx w_idx;
    logic                w_wr;

    assign w_idx  = fajsj_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_zone  <= fajsj_pkg::DEAD_ZONE_RST;
            r_cfg.home_angle <= fajsj_pkg::HOME_ANGLE_RST;
            r_cfg.max_angle  <= fajsj_pkg::MAX_ANGLE_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                fajsj_pkg::REG_DEAD_ZONE:  r_cfg.dead_zone  <= pwdata[6:0];
                fajsj_pkg::REG_HOME_ANGLE: r_cfg.home_angle <= pwdata[7:0];
                fajsj_pkg::REG_MAX_ANGLE:  r_cfg.max_angle  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            fajsj_pkg::REG_DEAD_ZONE:  prdata = {25'd0, r_cfg.dead_zone};
            fajsj_pkg::REG_HOME_ANGLE: prdata = {24'd0, r_cfg.home_angle};
            fajsj_pkg::REG_MAX_ANGLE:  prdata = {24'd0, r_cfg.max_angle};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/fajsj_joint.sv
module fajsj_joint #(
    parameter int STEP_DIVISOR = fajsj_pkg::STEP_DIVISOR_DEF
) (
    input  logic signed [7:0] i_stick,
    input  logic              i_move,
    input  fajsj_pkg::t_pos   i_pos,
    input  logic [6:0]        i_dead_zone,
    input  logic [7:0]        i_max_angle,
    output logic signed [7:0] o_step,
    output fajsj_pkg::t_pos   o_pos
);

    localparam int          RECIP_SHIFT = 16;
    localparam int          RECIP       = ((2 ** RECIP_SHIFT) + STEP_DIVISOR - 1) / STEP_DIVISOR;
    localparam logic [16:0] RECIP_V     = 17'(RECIP);

    logic [7:0]        w_mag;
    logic [24:0]       w_prod;
    logic [7:0]        w_quot;
    logic signed [7:0] w_step;
    logic signed [8:0] w_stick;
    logic signed [8:0] w_dz;
    logic signed [9:0] w_pos;
    logic signed [9:0] w_max;
    logic              w_allow;

    // The reciprocal is exact for every stick magnitude up to 128.
    assign w_mag  = i_stick[7] ? (~i_stick + 8'd1) : i_stick;
    assign w_prod = {17'd0, w_mag} * {8'd0, RECIP_V};
    assign w_quot = w_prod[RECIP_SHIFT+7:RECIP_SHIFT];
    assign w_step = i_stick[7] ? $signed(~w_quot + 8'd1) : $signed(w_quot);

    assign w_stick = {i_stick[7], i_stick};
    assign w_dz    = $signed({2'b00, i_dead_zone});
    assign w_pos   = {i_pos[8], i_pos};
    assign w_max   = $signed({2'b00, i_max_angle});

    assign w_allow = i_move && (((w_stick < -w_dz) && (w_pos < w_max))
                             || ((w_stick > w_dz) && (w_pos > 10'sd0)));

    assign o_step = w_allow ? w_step : 8'sd0;
    assign o_pos  = fajsj_pkg::sat_pos(fajsj_pkg::t_wide'(i_pos)
                                       - fajsj_pkg::t_wide'(o_step));

endmodule

FILE: dv/testbench.sv
module testbench;

    localparam int STEP_DIV = fajsj_pkg::STEP_DIVISOR_DEF;
    localparam int J_BASE     = 0;
    localparam int J_SHOULDER = 1;
    localparam int J_ELBOW    = 2;
    localparam int J_WRIST    = 3;

    localparam logic [3:0] MV_NONE = 4'b0000;
    localparam logic [3:0] MV_ALL  = 4'b1111;
    localparam logic [3:0] MV_LY   = 4'b0100;
    localparam logic [3:0] PR_NONE   = 4'b0000;
    localparam logic [3:0] PR_FREEZE = 4'b1000;
    localparam logic [3:0] PR_LOCK   = 4'b0100;
    localparam logic [3:0] PR_HOME_L = 4'b0010;
    localparam logic [3:0] PR_HOME_R = 4'b0001;
    localparam logic [3:0] PR_ALL    = 4'b1111;

    localparam int NUM_PHASES   = 8;
    localparam int RAND_PER_PH  = 205;
    localparam int IDLE_PCT     = 37;

    typedef struct {
        logic signed [7:0] left_x;
        logic signed [7:0] left_y;
        logic signed [7:0] right_x;
        logic signed [7:0] right_y;
        logic              moved_left_x;
        logic              moved_left_y;
        logic              moved_right_x;
        logic              moved_right_y;
        logic              press_freeze;
        logic              press_lock;
        logic              press_home_left;
        logic              press_home_right;
    } t_stick_event;

    typedef struct {
        logic [7:0] base_angle;
        logic [7:0] shoulder_angle;
        logic [7:0] elbow_angle;
        logic [7:0] wrist_angle;
        logic       frozen;
        logic       elbow_coupled;
    } t_joint_angles;

    class joint_tracker;
        fajsj_pkg::t_cfg cfg;
        int              pos[4];
        bit              frozen_flag;
        bit              coupled_flag;
        t_joint_angles   expected_angles[$];
        int              errors;

        function new();
            cfg.dead_zone  = fajsj_pkg::DEAD_ZONE_RST;
            cfg.home_angle = fajsj_pkg::HOME_ANGLE_RST;
            cfg.max_angle  = fajsj_pkg::MAX_ANGLE_RST;
            foreach (pos[j]) pos[j] = int'(fajsj_pkg::RESET_HOME);
            frozen_flag  = 1'b0;
            coupled_flag = 1'b0;
            errors       = 0;
        endfunction

        function void set_reg(fajsj_pkg::t_reg_idx idx, logic [31:0] val);
            case (idx)
                fajsj_pkg::REG_DEAD_ZONE:  cfg.dead_zone  = val[6:0];
                fajsj_pkg::REG_HOME_ANGLE: cfg.home_angle = val[7:0];
                fajsj_pkg::REG_MAX_ANGLE:  cfg.max_angle  = val[7:0];
                default: ;
            endcase
        endfunction

        function int limit_pos(int v);
            if (v < int'(fajsj_pkg::POS_MIN)) return int'(fajsj_pkg::POS_MIN);
            if (v > int'(fajsj_pkg::POS_MAX)) return int'(fajsj_pkg::POS_MAX);
            return v;
        endfunction

        function logic [7:0] servo_clamp(int v);
            int hi;
            hi = int'(cfg.max_angle);
            if (v < 0) v = 0;
            if (v > hi) v = hi;
            return v[7:0];
        endfunction

        function int jog_amount(int stick, int p);
            int dz;
            dz = int'(cfg.dead_zone);
            if (stick < -dz && p < int'(cfg.max_angle)) return stick / STEP_DIV;
            if (stick > dz && p > 0) return stick / STEP_DIV;
            return 0;
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction

        function void accept_event(t_stick_event ev);
            int            home;
            int            s;
            t_joint_angles r;
            home = limit_pos(int'(cfg.home_angle));
            if (ev.press_freeze) frozen_flag = !frozen_flag;
            if (!frozen_flag) begin
                if (ev.press_lock) coupled_flag = !coupled_flag;
                if (ev.press_home_left) begin
                    pos[J_BASE]     = home;
                    pos[J_SHOULDER] = home;
                end
                if (ev.moved_left_x) begin
                    s = jog_amount(ev.left_x, pos[J_BASE]);
                    pos[J_BASE] = limit_pos(pos[J_BASE] - s);
                end
                if (ev.moved_left_y) begin
                    s = jog_amount(ev.left_y, pos[J_SHOULDER]);
                    pos[J_SHOULDER] = limit_pos(pos[J_SHOULDER] - s);
                    if (coupled_flag) pos[J_ELBOW] = limit_pos(pos[J_ELBOW] + s);
                end
                if (ev.press_home_right) begin
                    pos[J_ELBOW] = home;
                    pos[J_WRIST] = home;
                end
                if (ev.moved_right_x) begin
                    s = jog_amount(ev.right_x, pos[J_WRIST]);
                    pos[J_WRIST] = limit_pos(pos[J_WRIST] - s);
                end
                if (ev.moved_right_y) begin
                    s = jog_amount(ev.right_y, pos[J_ELBOW]);
                    pos[J_ELBOW] = limit_pos(pos[J_ELBOW] - s);
                end
            end
            r.base_angle     = servo_clamp(pos[J_BASE]);
            r.shoulder_angle = servo_clamp(pos[J_SHOULDER]);
            r.elbow_angle    = servo_clamp(pos[J_ELBOW]);
            r.wrist_angle    = servo_clamp(pos[J_WRIST]);
            r.frozen         = frozen_flag;
            r.elbow_coupled  = coupled_flag;
            expected_angles.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
            if (got_v !== want_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want_v, got_v);
            end
        endfunction

        function void check_angles(t_joint_angles got);
            t_joint_angles want;
            if (expected_angles.size() == 0) begin
                errors++;
                $display("%0t: beat with nothing expected, expected none, %s %0d %0d %0d %0d",
                         $time, "actual", got.base_angle, got.shoulder_angle,
                         got.elbow_angle, got.wrist_angle);
                return;
            end
            want = expected_angles.pop_front();
            compare_field("base_angle", want.base_angle, got.base_angle);
            compare_field("shoulder_angle", want.shoulder_angle, got.shoulder_angle);
            compare_field("elbow_angle", want.elbow_angle, got.elbow_angle);
            compare_field("wrist_angle", want.wrist_angle, got.wrist_angle);
            compare_field("frozen", want.frozen, got.frozen);
            compare_field("elbow_coupled", want.elbow_coupled, got.elbow_coupled);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_valid;
    logic              o_ready;
    logic signed [7:0] i_left_x;
    logic signed [7:0] i_left_y;
    logic signed [7:0] i_right_x;
    logic signed [7:0] i_right_y;
    logic              i_moved_left_x;
    logic              i_moved_left_y;
    logic              i_moved_right_x;
    logic              i_moved_right_y;
    logic              i_press_freeze;
    logic              i_press_lock;
    logic              i_press_home_left;
    logic              i_press_home_right;
    logic              o_valid;
    logic              i_ready;
    logic [7:0]        o_base_angle;
    logic [7:0]        o_shoulder_angle;
    logic [7:0]        o_elbow_angle;
    logic [7:0]        o_wrist_angle;
    logic              o_frozen;
    logic              o_elbow_coupled;

    joint_tracker sb;
    int           sent_count = 0;
    bit [3:0]     drift_up   = 4'b0000;

    four_axis_joystick_servo_jog_top u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_left_x           (i_left_x),
        .i_left_y           (i_left_y),
        .i_right_x          (i_right_x),
        .i_right_y          (i_right_y),
        .i_moved_left_x     (i_moved_left_x),
        .i_moved_left_y     (i_moved_left_y),
        .i_moved_right_x    (i_moved_right_x),
        .i_moved_right_y    (i_moved_right_y),
        .i_press_freeze     (i_press_freeze),
        .i_press_lock       (i_press_lock),
        .i_press_home_left  (i_press_home_left),
        .i_press_home_right (i_press_home_right),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_base_angle       (o_base_angle),
        .o_shoulder_angle   (o_shoulder_angle),
        .o_elbow_angle      (o_elbow_angle),
        .o_wrist_angle      (o_wrist_angle),
        .o_frozen           (o_frozen),
        .o_elbow_coupled    (o_elbow_coupled)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit quiet_stretch();
        return sent_count >= 700 && sent_count < 900;
    endfunction

    function automatic t_stick_event mk_event(input int lx, ly, rx, ry,
                                              input logic [3:0] moved, press);
        t_stick_event ev;
        ev.left_x           = lx[7:0];
        ev.left_y           = ly[7:0];
        ev.right_x          = rx[7:0];
        ev.right_y          = ry[7:0];
        ev.moved_left_x     = moved[3];
        ev.moved_left_y     = moved[2];
        ev.moved_right_x    = moved[1];
        ev.moved_right_y    = moved[0];
        ev.press_freeze     = press[3];
        ev.press_lock       = press[2];
        ev.press_home_left  = press[1];
        ev.press_home_right = press[0];
        return ev;
    endfunction

    function automatic logic signed [7:0] random_stick(input int axis);
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = drift_up[axis] ? int'($urandom_range(50, 127))
                                           : -int'($urandom_range(50, 128));
            4: v = $urandom_range(1) ? 127 : -128;
            5: begin
                v = int'(sb.cfg.dead_zone) + int'($urandom_range(2)) - 1;
                if (v > 127) v = 127;
                if (v < 0) v = 0;
                if ($urandom_range(1)) v = -v;
            end
            default: v = int'($urandom_range(255)) - 128;
        endcase
        return v[7:0];
    endfunction

    function automatic t_stick_event random_event();
        t_stick_event ev;
        ev.left_x           = random_stick(J_BASE);
        ev.left_y           = random_stick(J_SHOULDER);
        ev.right_x          = random_stick(J_WRIST);
        ev.right_y          = random_stick(J_ELBOW);
        ev.moved_left_x     = 1'($urandom_range(1));
        ev.moved_left_y     = 1'($urandom_range(1));
        ev.moved_right_x    = 1'($urandom_range(1));
        ev.moved_right_y    = 1'($urandom_range(1));
        ev.press_freeze     = sb.frozen_flag ? ($urandom_range(3) == 0)
                                             : ($urandom_range(39) == 0);
        ev.press_lock       = ($urandom_range(9) == 0);
        ev.press_home_left  = ($urandom_range(39) == 0);
        ev.press_home_right = ($urandom_range(39) == 0);
        return ev;
    endfunction

    task automatic apb_write(input fajsj_pkg::t_reg_idx idx, input logic [31:0] val);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_event(input t_stick_event ev);
        while (!quiet_stretch() && $urandom_range(99) < IDLE_PCT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_left_x           = ev.left_x;
        i_left_y           = ev.left_y;
        i_right_x          = ev.right_x;
        i_right_y          = ev.right_y;
        i_moved_left_x     = ev.moved_left_x;
        i_moved_left_y     = ev.moved_left_y;
        i_moved_right_x    = ev.moved_right_x;
        i_moved_right_y    = ev.moved_right_y;
        i_press_freeze     = ev.press_freeze;
        i_press_lock       = ev.press_lock;
        i_press_home_left  = ev.press_home_left;
        i_press_home_right = ev.press_home_right;
        i_valid            = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.accept_event(ev);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic send_directed();
        send_event(mk_event(0, 0, 0, 0, MV_NONE, PR_NONE));
        send_event(mk_event(127, 127, 127, 127, MV_ALL, PR_NONE));
        send_event(mk_event(-128, -128, -128, -128, MV_ALL, PR_NONE));
        send_event(mk_event(2, 2, 2, 2, MV_ALL, PR_NONE));
        send_event(mk_event(-2, -2, -2, -2, MV_ALL, PR_NONE));
        send_event(mk_event(3, -3, 49, -49, MV_ALL, PR_NONE));
        send_event(mk_event(50, 50, 50, 50, MV_ALL, PR_NONE));
        send_event(mk_event(-50, -50, -50, -50, MV_ALL, PR_NONE));
        send_event(mk_event(127, -128, 127, -128, MV_NONE, PR_NONE));
        send_event(mk_event(0, 0, 0, 0, MV_NONE, PR_LOCK));
        send_event(mk_event(0, -128, 0, 0, MV_LY, PR_NONE));
        send_event(mk_event(127, 127, 127, 127, MV_ALL, PR_NONE));
        send_event(mk_event(0, 0, 0, 0, MV_NONE, PR_HOME_L));
        send_event(mk_event(0, 0, 0, 0, MV_NONE, PR_HOME_R));
        send_event(mk_event(0, 0, 0, 0, MV_NONE, PR_FREEZE));
        send_event(mk_event(127, 127, 127, 127, MV_ALL, PR_LOCK | PR_HOME_L | PR_HOME_R));
        send_event(mk_event(-128, -128, -128, -128, MV_ALL, PR_ALL));
        send_event(mk_event(0, 127, 0, 0, MV_LY, PR_LOCK));
        send_event(mk_event(127, 127, 127, 127, MV_ALL, PR_ALL));
        send_event(mk_event(0, 0, 0, 0, MV_NONE, PR_FREEZE));
        send_event(mk_event(-100, 100, -100, 100, MV_ALL, PR_FREEZE));
    endtask

    initial begin : main_seq
        int unsigned ph_dead_zone[NUM_PHASES]  = '{2, 0, 127, 10, 0, 5, 1, 0};
        int unsigned ph_home_angle[NUM_PHASES] = '{90, 0, 180, 255, 182, 200, 183, 0};
        int unsigned ph_max_angle[NUM_PHASES]  = '{180, 1, 180, 0, 255, 100, 179, 0};
        sb                 = new();
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        i_valid            = 1'b0;
        i_left_x           = '0;
        i_left_y           = '0;
        i_right_x          = '0;
        i_right_y          = '0;
        i_moved_left_x     = 1'b0;
        i_moved_left_y     = 1'b0;
        i_moved_right_x    = 1'b0;
        i_moved_right_y    = 1'b0;
        i_press_freeze     = 1'b0;
        i_press_lock       = 1'b0;
        i_press_home_left  = 1'b0;
        i_press_home_right = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == NUM_PHASES - 1) begin
                ph_dead_zone[ph]  = $urandom_range(127);
                ph_home_angle[ph] = $urandom_range(255);
                ph_max_angle[ph]  = $urandom_range(255);
            end
            apb_write(fajsj_pkg::REG_DEAD_ZONE, ph_dead_zone[ph]);
            apb_write(fajsj_pkg::REG_HOME_ANGLE, ph_home_angle[ph]);
            apb_write(fajsj_pkg::REG_MAX_ANGLE, ph_max_angle[ph]);
            if (ph == 0) send_directed();
            for (int n = 0; n < RAND_PER_PH; n++) begin
                if (n % 60 == 0) drift_up = 4'($urandom_range(15));
                send_event(random_event());
            end
            wait_drained();
        end
        repeat (4) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && sent_count >= 400) begin
                hold_done = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else begin
                i_ready = quiet_stretch() || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        t_joint_angles got;
        if (i_rst_n && o_valid && i_ready) begin
            got.base_angle     = o_base_angle;
            got.shoulder_angle = o_shoulder_angle;
            got.elbow_angle    = o_elbow_angle;
            got.wrist_angle    = o_wrist_angle;
            got.frozen         = o_frozen;
            got.elbow_coupled  = o_elbow_coupled;
            sb.check_angles(got);
        end
    end

    initial begin : watchdog
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: four_axis_joystick_servo_jog_top.f
rtl/fajsj_pkg.sv
rtl/fajsj_cfg.sv
rtl/fajsj_joint.sv
rtl/four_axis_joystick_servo_jog_top.sv
dv/testbench.sv
